[rtl/vlrd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vlrd_pkg;

    localparam int LEN_W = 17;
    localparam int ACC_W = 32;
    localparam int IDX_W = 3;
    localparam int ERR_W = 3;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 17'd65536;
    localparam logic [IDX_W-1:0] LAST_LEN_IDX  = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_TRUNC_LEN  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_LEN_OVF    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_LEN    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TRUNC_BODY = 3'd4;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_BODY = 2'd1,
        PH_HALT = 2'd2
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       body_byte;
        logic             last_in_record;
        logic [LEN_W-1:0] record_len;
        logic [ERR_W-1:0] error_code;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/vlrd_out_buf.sv]
`timescale 1ns / 1ps
`default_nettype none

module vlrd_out_buf (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_push,
    input  wire vlrd_pkg::t_out_item  i_push_data,
    output logic                      o_push_ready,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output vlrd_pkg::t_out_item       o_out_data
);
    import vlrd_pkg::*;

    logic      r_out_vld, n_out_vld;
    logic      r_skd_vld, n_skd_vld;
    t_out_item r_out, n_out;
    t_out_item r_skd, n_skd;
    logic      w_pop;

    assign w_pop = r_out_vld && i_out_ready;

    always_comb begin
        n_out_vld = r_out_vld;
        n_skd_vld = r_skd_vld;
        n_out     = r_out;
        n_skd     = r_skd;
        if (w_pop) begin
            if (r_skd_vld) begin
                n_out     = r_skd;
                n_out_vld = 1'b1;
                n_skd     = i_push_data;
                n_skd_vld = i_push;
            end else begin
                n_out     = i_push_data;
                n_out_vld = i_push;
            end
        end else if (i_push) begin
            if (!r_out_vld) begin
                n_out     = i_push_data;
                n_out_vld = 1'b1;
            end else begin
                n_skd     = i_push_data;
                n_skd_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_skd_vld <= n_skd_vld;
        end
        r_out <= n_out;
        r_skd <= n_skd;
    end

    assign o_push_ready = !r_skd_vld;
    assign o_out_valid  = r_out_vld;
    assign o_out_data   = r_out;

`ifndef SYNTH
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid entry held without output entry");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skd_vld)
        else $error("request pushed into full output buffer");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skd_vld && w_pop) |=> (o_out_valid && o_out_data == $past(r_skd)))
        else $error("skid entry lost on pop");
`endif

endmodule

`default_nettype wire

[rtl/varint_length_record_deframer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Varint length-delimited record deframer. Each record is led by a little-endian
// base-128 length of up to five bytes; body bytes come out one per request with
// the record length and a last-byte flag. Length bytes and a clean end of stream
// give no output. A framing error gives one error request and the block then
// swallows all input until reset. Throughput is one input request per cycle
// while the output buffer can take its result, set by the combinational decode
// step between the input register and the two-entry output buffer; a request is
// held in the input register and its result is registered in the buffer. While
// the output is stalled the buffer holds two results, and the next request that
// gives a result waits in the input register and stops input. The configuration
// port is always ready and may only be written while the block is idle.
module varint_length_record_deframer_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire vlrd_pkg::t_in_item     i_in_data,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output vlrd_pkg::t_out_item         o_out_data,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [vlrd_pkg::LEN_W-1:0]   i_cfg_data
);
    import vlrd_pkg::*;

    logic             r_in_vld;
    t_in_item         r_in;
    logic [LEN_W-1:0] r_max_len;

    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_acc, n_acc;
    logic             r_big, n_big;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [LEN_W-1:0] r_cur, n_cur;

    logic             w_has_res;
    t_out_item        w_res;
    logic             w_push_ready;
    logic             w_proc;
    logic [4:0]       w_shamt;
    logic [ACC_W-1:0] w_shifted;
    logic [LEN_W-1:0] w_acc_new;
    logic             w_big_new;
    logic [LEN_W-1:0] w_rem_dec;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        case (r_idx)
            3'd0:    w_shamt = 5'd0;
            3'd1:    w_shamt = 5'd7;
            3'd2:    w_shamt = 5'd14;
            3'd3:    w_shamt = 5'd21;
            default: w_shamt = 5'd28;
        endcase
    end

    assign w_shifted = {{(ACC_W-7){1'b0}}, r_in.data_byte[6:0]} << w_shamt;
    assign w_acc_new = r_acc | w_shifted[LEN_W-1:0];
    assign w_big_new = r_big | (|w_shifted[ACC_W-1:LEN_W]);
    assign w_rem_dec = (r_rem != '0) ? r_rem - 1'b1 : r_rem;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_big   = r_big;
        n_idx   = r_idx;
        n_rem   = r_rem;
        n_cur   = r_cur;
        if (r_in_vld && r_phase != PH_HALT) begin
            if (r_in.kind == KIND_END) begin
                if (r_phase == PH_BODY || r_idx != '0) begin
                    n_phase = PH_HALT;
                end
            end else if (r_phase == PH_LEN) begin
                if (r_idx == LAST_LEN_IDX && r_in.data_byte[7:4] != 4'd0) begin
                    n_phase = PH_HALT;
                end else if (r_in.data_byte[7] && r_idx != LAST_LEN_IDX) begin
                    n_acc = w_acc_new;
                    n_big = w_big_new;
                    n_idx = r_idx + 1'b1;
                end else if (w_big_new || w_acc_new == '0 || w_acc_new > r_max_len) begin
                    n_phase = PH_HALT;
                end else begin
                    n_cur   = w_acc_new;
                    n_rem   = w_acc_new;
                    n_acc   = '0;
                    n_big   = 1'b0;
                    n_idx   = '0;
                    n_phase = PH_BODY;
                end
            end else begin
                n_rem = w_rem_dec;
                if (w_rem_dec == '0) begin
                    n_phase = PH_LEN;
                end
            end
        end
    end

    // result
    always_comb begin
        w_has_res = 1'b0;
        w_res     = '0;
        if (r_in_vld && r_phase != PH_HALT) begin
            if (r_in.kind == KIND_END) begin
                if (r_phase == PH_BODY) begin
                    w_has_res        = 1'b1;
                    w_res.record_len = r_cur;
                    w_res.error_code = ERR_TRUNC_BODY;
                end else if (r_idx != '0) begin
                    w_has_res        = 1'b1;
                    w_res.error_code = ERR_TRUNC_LEN;
                end
            end else if (r_phase == PH_LEN) begin
                if (r_idx == LAST_LEN_IDX && r_in.data_byte[7:4] != 4'd0) begin
                    w_has_res        = 1'b1;
                    w_res.error_code = ERR_LEN_OVF;
                end else if (!(r_in.data_byte[7] && r_idx != LAST_LEN_IDX) &&
                             (w_big_new || w_acc_new == '0 || w_acc_new > r_max_len)) begin
                    w_has_res        = 1'b1;
                    w_res.error_code = ERR_BAD_LEN;
                end
            end else begin
                w_has_res            = 1'b1;
                w_res.body_byte      = r_in.data_byte;
                w_res.last_in_record = (w_rem_dec == '0);
                w_res.record_len     = r_cur;
                w_res.error_code     = ERR_NONE;
            end
        end
    end

    assign w_proc     = r_in_vld && (!w_has_res || w_push_ready);
    assign o_in_ready = !r_in_vld || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_max_len <= MAX_LEN_RESET;
            r_phase   <= PH_LEN;
            r_acc     <= '0;
            r_big     <= 1'b0;
            r_idx     <= '0;
            r_rem     <= '0;
            r_cur     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
            if (w_proc) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_big   <= n_big;
                r_idx   <= n_idx;
                r_rem   <= n_rem;
                r_cur   <= n_cur;
            end
        end
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    vlrd_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_proc && w_has_res),
        .i_push_data  (w_res),
        .o_push_ready (w_push_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

`ifndef SYNTH
    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HALT && i_rst_n) |=> r_phase == PH_HALT)
        else $error("left halted state without reset");

    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_has_res && w_res.error_code != ERR_NONE && i_rst_n)
        |=> r_phase == PH_HALT)
        else $error("error request without halt");

    a_body_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> (r_rem != '0 && r_rem <= r_cur))
        else $error("body phase with bad remaining count");
`endif

endmodule

`default_nettype wire
